// ----- rtl/core/hid_output_report_finder_assert.svh -----
// Assertion macros shared by the RTL of the HID output report finder.
// Both sample on clk and are switched off while arst_n is low.
`ifndef HID_OUTPUT_REPORT_FINDER_ASSERT_SVH
`define HID_OUTPUT_REPORT_FINDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define HOF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HOF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hof_pkg.sv -----
package hof_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_PREFIX     = 3'd0,
		PH_LONG_SIZE  = 3'd1,
		PH_LONG_TAG   = 3'd2,
		PH_LONG_DATA  = 3'd3,
		PH_SHORT_DATA = 3'd4,
		PH_DONE       = 3'd5
	} hof_phase_t;

	// Result of one parser step
	typedef struct packed {
		logic emit;
		logic found;
	} hof_res_t;

	localparam logic [7:0] LONG_PREFIX    = 8'hFE;
	localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
	localparam logic [1:0] TYPE_MAIN      = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL    = 2'd1;
	localparam logic [3:0] TAG_OUTPUT     = 4'h9;
	localparam logic [3:0] TAG_REPORT_ID  = 4'h8;

endpackage

// ----- rtl/core/hof_parser.sv -----
module hof_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [7:0]      byte_s1,
	input  logic            final_s1,
	input  logic [7:0]      wanted_id,
	output hof_pkg::hof_res_t res,
	output logic            done
);
	import hof_pkg::*;

	hof_phase_t phase_q, phase_d;
	logic [7:0] left_q, left_d;
	logic [7:0] cur_id_q, cur_id_d;
	logic       is_rid_q, is_rid_d;
	logic       is_match_q, is_match_d;
	logic       hit;
	logic [1:0] code, itype;
	logic [3:0] tag;
	logic [2:0] size;
	logic       out_hit;

	// Split the item prefix
	assign code    = byte_s1[1:0];
	assign itype   = byte_s1[3:2];
	assign tag     = byte_s1[7:4];
	assign size    = (code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, code};
	assign out_hit = (itype == TYPE_MAIN) && (tag == TAG_OUTPUT) && (cur_id_q == wanted_id);

	// Advance the parser by one byte
	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		cur_id_d   = cur_id_q;
		is_rid_d   = is_rid_q;
		is_match_d = is_match_q;
		hit        = 1'b0;
		case (phase_q)
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			PH_LONG_SIZE: begin
				left_d  = byte_s1;
				phase_d = PH_LONG_TAG;
			end
			PH_LONG_TAG: begin
				phase_d = (left_q == 8'd0) ? PH_PREFIX : PH_LONG_DATA;
			end
			PH_LONG_DATA: begin
				left_d = left_q - 8'd1;
				if (left_q == 8'd1) begin
					phase_d = PH_PREFIX;
				end
			end
			PH_SHORT_DATA: begin
				if (is_rid_q) begin
					cur_id_d = byte_s1;
				end
				left_d = left_q - 8'd1;
				if (left_q == 8'd1) begin
					phase_d = PH_PREFIX;
					hit     = is_match_q;
				end
			end
			default: begin
				if (byte_s1 == LONG_PREFIX) begin
					phase_d = PH_LONG_SIZE;
				end else if (size == 3'd0) begin
					phase_d = PH_PREFIX;
					hit     = out_hit;
				end else begin
					is_rid_d   = (itype == TYPE_GLOBAL) && (tag == TAG_REPORT_ID) &&
					             (size == 3'd1);
					is_match_d = out_hit;
					left_d     = {5'd0, size};
					phase_d    = PH_SHORT_DATA;
				end
			end
		endcase
		// a hit ends the search for this descriptor
		if (hit) begin
			phase_d = PH_DONE;
		end
		// the last byte restarts the parser
		if (final_s1) begin
			phase_d    = PH_PREFIX;
			left_d     = 8'd0;
			cur_id_d   = 8'd0;
			is_rid_d   = 1'b0;
			is_match_d = 1'b0;
		end
	end

	// Give a word on a hit, or a miss at the last byte
	always_comb begin
		res.emit  = adv && (hit || (final_s1 && (phase_q != PH_DONE)));
		res.found = hit;
	end

	assign done = (phase_q == PH_DONE);

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PREFIX;
			left_q     <= 8'd0;
			cur_id_q   <= 8'd0;
			is_rid_q   <= 1'b0;
			is_match_q <= 1'b0;
		end else if (adv) begin
			phase_q    <= phase_d;
			left_q     <= left_d;
			cur_id_q   <= cur_id_d;
			is_rid_q   <= is_rid_d;
			is_match_q <= is_match_d;
		end
	end

endmodule

// ----- rtl/core/hof_out_stage.sv -----
module hof_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  hof_pkg::hof_res_t res,
	input  logic              out_stall,
	output logic              out_free,
	output logic              out_valid,
	output logic              found
);
	import hof_pkg::*;

	logic valid_q;
	logic found_q;

	// Register is free when empty or being taken this cycle
	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign found     = found_q;

	// Load a new word, drop a taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.emit) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the result bit
	always_ff @(posedge clk) begin
		if (res.emit) begin
			found_q <= res.found;
		end
	end

endmodule

// ----- rtl/core/hid_output_report_finder.sv -----
// HID report descriptor Output item finder.
// Input channel: one descriptor byte per word on desc_byte, with final_byte
// high on the last byte, handshaked by in_valid / in_stall.
// Output channel: one word per descriptor on found, handshaked by
// out_valid / out_stall. found is 1 at the byte that completes a Main
// Output item while the current report id equals the configured wanted id,
// else 0 at the last byte; bytes after a hit give no further word.
// cfg_we / cfg_wdata write the wanted report id; write only while idle.
// A taken byte goes through the input register, then is decoded into the
// output register, before its word shows on out_valid.
// Throughput: one byte per cycle unless stalled; the parse state lives
// in a single decode step between the input and the output registers.
// Reset clears the parser, both register valid flags and the wanted id to 0.
// When the receiver stalls, the output word holds; the input register
// still takes one more byte, then in_stall rises until the word is taken.
module hid_output_report_finder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] desc_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import hof_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic [7:0] wanted_q;
	logic       out_free;
	logic       adv;
	logic       done;
	hof_res_t   res;

	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Hold the wanted report id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= 8'd0;
		end else if (cfg_we) begin
			wanted_q <= cfg_wdata;
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= desc_byte;
			final_s1 <= final_byte;
		end
	end

	hof_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.byte_s1   (byte_s1),
		.final_s1  (final_s1),
		.wanted_id (wanted_q),
		.res       (res),
		.done      (done)
	);

	hof_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.found     (found)
	);

`include "hid_output_report_finder_assert.svh"

	`HOF_ASSERT_SAME(a_stall_needs_word, in_stall, valid_s1, "input stalled with empty register")
	`HOF_ASSERT_NEXT(a_hit_ends_search, res.emit && res.found && !final_s1, done, "hit did not end the search")
	`HOF_ASSERT_SAME(a_one_answer, adv && done, !res.emit || !res.found, "second hit in a descriptor")
	`HOF_ASSERT_NEXT(a_emit_shows, res.emit, out_valid, "result word lost")

endmodule
